// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, constants and the microcode table of the text console writer.
package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;
    localparam int INDEX_W         = 11;
    localparam int BCD_DIGITS      = 10;
    localparam int BCD_W           = 4 * BCD_DIGITS;

    // Loop bounds of the sequencer, as the last count value of each loop.
    localparam logic [4:0] HEX_LAST    = 5'd7;
    localparam logic [4:0] DABBLE_LAST = 5'd31;
    localparam logic [3:0] DIGIT_LAST  = 4'(BCD_DIGITS - 1);

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [3:0] HEX_TEN      = 4'd10;

    typedef enum logic [1:0] {
        ACT_CHAR = 2'd0,
        ACT_DEC  = 2'd1,
        ACT_HEX  = 2'd2,
        ACT_BKSP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_FETCH  = 3'd0,
        S_CHAR   = 3'd1,
        S_BKSP   = 3'd2,
        S_HEX    = 3'd3,
        S_SIGN   = 3'd4,
        S_DABBLE = 3'd5,
        S_SKIP   = 3'd6,
        S_DIGIT  = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_CHAR,
        OP_BKSP,
        OP_HEX,
        OP_SIGN,
        OP_DABBLE,
        OP_SKIP,
        OP_DIGIT
    } op_t;

    typedef enum logic [2:0] {
        COND_DISPATCH,
        COND_ALWAYS,
        COND_HEX_MORE,
        COND_DABBLE_MORE,
        COND_SKIP_MORE,
        COND_DIGIT_MORE
    } cond_t;

    // One control word: the operation, a branch condition and both successors.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target_true;
        step_t target_false;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        unique case (step)
            S_FETCH:  word = '{OP_FETCH,  COND_DISPATCH,    S_FETCH,  S_FETCH};
            S_CHAR:   word = '{OP_CHAR,   COND_ALWAYS,      S_FETCH,  S_FETCH};
            S_BKSP:   word = '{OP_BKSP,   COND_ALWAYS,      S_FETCH,  S_FETCH};
            S_HEX:    word = '{OP_HEX,    COND_HEX_MORE,    S_HEX,    S_FETCH};
            S_SIGN:   word = '{OP_SIGN,   COND_ALWAYS,      S_DABBLE, S_DABBLE};
            S_DABBLE: word = '{OP_DABBLE, COND_DABBLE_MORE, S_DABBLE, S_SKIP};
            S_SKIP:   word = '{OP_SKIP,   COND_SKIP_MORE,   S_SKIP,   S_DIGIT};
            S_DIGIT:  word = '{OP_DIGIT,  COND_DIGIT_MORE,  S_DIGIT,  S_FETCH};
        endcase
        return word;
    endfunction

    function automatic step_t dispatch(input action_t act);
        step_t step;
        unique case (act)
            ACT_CHAR: step = S_CHAR;
            ACT_DEC:  step = S_SIGN;
            ACT_HEX:  step = S_HEX;
            ACT_BKSP: step = S_BKSP;
        endcase
        return step;
    endfunction

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// Text console writer: cursor keeping and character formatting for a text screen.
//
// Input channel (in_valid, in_stall, action, value): one word per console action:
// a character, a signed decimal number, eight hex digits or a backspace.
// Output channel (out_valid, out_stall, ...): one word per cell write or cursor
// move, with the cell index, the character, the cursor index after that step and
// a last flag on the final word of the action. A backspace at column 0 yields none.
// A small microcode table steps a plain datapath; the input is taken only while
// the sequencer sits at its fetch step, so actions run one at a time.
// A character or backspace runs fetch and one step, hex fetch and one step per digit, decimal
// fetch, one sign step, 32 shift-and-add-3 steps that form the BCD digits, then 11 steps that
// drop the leading zeros, leave that loop and print one digit each. The first word of a
// character, backspace, hex or minus sign is formed at the step after fetch and registered.
// A stalled output word holds the sequencer at its next emitting step; the result
// register holds one word while the sequencer carries on with steps that emit nothing.
// Reset puts the cursor at row 0, column 0 and the sequencer at fetch, output empty.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [31:0]        value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_valid,
    output logic [INDEX_W-1:0] cell_index,
    output logic [7:0]         char_code,
    output logic [INDEX_W-1:0] cursor_index,
    output logic               last
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    function automatic logic [INDEX_W-1:0] pos(input logic [CW-1:0] col,
                                               input logic [RW-1:0] row);
        logic [31:0] sum;
        sum = 32'(col) + 32'(COLUMNS) * 32'(row);
        return sum[INDEX_W-1:0];
    endfunction

    step_t              pc_reg, pc_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [31:0]        work_reg, work_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [4:0]         count_reg, count_next;
    logic [3:0]         dig_reg, dig_next;

    logic               out_valid_reg, out_valid_next;
    logic               wv_reg, wv_next;
    logic [INDEX_W-1:0] cell_reg, cell_next;
    logic [7:0]         char_reg, char_next;
    logic [INDEX_W-1:0] cursor_reg, cursor_next;
    logic               last_reg, last_next;

    ucode_t             uword;
    logic               cond_true;
    logic               emit_req;
    logic               emit_bs;
    logic               emit_last;
    logic [7:0]         emit_ch;
    logic               out_free;
    logic               advance;
    logic               accept;
    logic [3:0]         hex_digit;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         bcd_top;
    logic [RW-1:0]      row_wrap;

    assign uword     = ucode_rom(pc_reg);
    assign in_stall  = (pc_reg != S_FETCH);
    assign accept    = in_valid && (pc_reg == S_FETCH);
    assign out_free  = !out_valid_reg || !out_stall;
    assign hex_digit = work_reg[31:28];
    assign bcd_top   = bcd_reg[BCD_W-1 -: 4];
    assign row_wrap  = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                            : bcd_reg[i*4 +: 4];
        end
    end

    // Operation decode: which character goes out and how the work registers move.
    always_comb
    begin
        emit_req   = 1'b0;
        emit_bs    = 1'b0;
        emit_last  = 1'b0;
        emit_ch    = '0;
        work_next  = work_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        dig_next   = dig_reg;
        unique case (uword.op)
            OP_FETCH:
            begin
                work_next  = value;
                count_next = '0;
            end
            OP_CHAR:
            begin
                emit_req  = 1'b1;
                emit_last = 1'b1;
                emit_ch   = work_reg[7:0];
            end
            OP_BKSP:
            begin
                emit_req  = (col_reg != '0);
                emit_bs   = 1'b1;
                emit_last = 1'b1;
                emit_ch   = CHAR_SPACE;
            end
            OP_HEX:
            begin
                emit_req   = 1'b1;
                emit_last  = (count_reg == HEX_LAST);
                emit_ch    = (hex_digit < HEX_TEN) ? CHAR_ZERO + 8'(hex_digit)
                                                   : CHAR_LOWER_A + 8'(hex_digit - HEX_TEN);
                work_next  = work_reg << 4;
                count_next = count_reg + 1'b1;
            end
            OP_SIGN:
            begin
                // The magnitude is taken as unsigned, so the most negative value fits.
                emit_req   = work_reg[31];
                emit_ch    = CHAR_MINUS;
                work_next  = work_reg[31] ? 32'd0 - work_reg : work_reg;
                bcd_next   = '0;
                count_next = '0;
                dig_next   = DIGIT_LAST;
            end
            OP_DABBLE:
            begin
                bcd_next   = {bcd_adj[BCD_W-2:0], work_reg[31]};
                work_next  = work_reg << 1;
                count_next = count_reg + 1'b1;
            end
            OP_SKIP:
            begin
                if (bcd_top == 4'd0 && dig_reg != 4'd0)
                begin
                    bcd_next = bcd_reg << 4;
                    dig_next = dig_reg - 1'b1;
                end
            end
            OP_DIGIT:
            begin
                emit_req  = 1'b1;
                emit_last = (dig_reg == 4'd0);
                emit_ch   = CHAR_ZERO + 8'(bcd_top);
                bcd_next  = bcd_reg << 4;
                dig_next  = dig_reg - 1'b1;
            end
        endcase
    end

    assign advance = (uword.op == OP_FETCH) ? accept : (!emit_req || out_free);

    always_comb
    begin
        unique case (uword.cond)
            COND_DISPATCH:    cond_true = 1'b1;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_HEX_MORE:    cond_true = (count_reg != HEX_LAST);
            COND_DABBLE_MORE: cond_true = (count_reg != DABBLE_LAST);
            COND_SKIP_MORE:   cond_true = (bcd_top == 4'd0 && dig_reg != 4'd0);
            COND_DIGIT_MORE:  cond_true = (dig_reg != 4'd0);
            default:          cond_true = 1'b0;
        endcase
    end

    // Step counter.
    always_comb
    begin
        pc_next = pc_reg;
        if (advance)
        begin
            if (uword.cond == COND_DISPATCH)
                pc_next = dispatch(action_t'(action));
            else
                pc_next = cond_true ? uword.target_true : uword.target_false;
        end
    end

    // Cursor update and the result word formed from it.
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        wv_next     = wv_reg;
        cell_next   = cell_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        cursor_next = cursor_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit_req && advance)
        begin
            out_valid_next = 1'b1;
            last_next      = emit_last;
            if (emit_bs)
            begin
                col_next  = col_reg - 1'b1;
                wv_next   = 1'b1;
                cell_next = pos(col_next, row_reg);
                char_next = CHAR_SPACE;
            end
            else if (emit_ch == CHAR_NEWLINE)
            begin
                col_next  = '0;
                row_next  = row_wrap;
                wv_next   = 1'b0;
                cell_next = '0;
                char_next = '0;
            end
            else
            begin
                wv_next   = 1'b1;
                cell_next = pos(col_reg, row_reg);
                char_next = emit_ch;
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    row_next = row_wrap;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            cursor_next = pos(col_next, row_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_FETCH;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg  <= work_next;
            bcd_reg   <= bcd_next;
            count_reg <= count_next;
            dig_reg   <= dig_next;
        end
        wv_reg     <= wv_next;
        cell_reg   <= cell_next;
        char_reg   <= char_next;
        cursor_reg <= cursor_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign write_valid  = wv_reg;
    assign cell_index   = cell_reg;
    assign char_code    = char_reg;
    assign cursor_index = cursor_reg;
    assign last         = last_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS))
        else $error("cursor outside the screen");

    a_last_returns_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_req && advance && emit_last) |=> (pc_reg == S_FETCH))
        else $error("sequencer did not return to fetch after the final word");

    a_bcd_digit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_DIGIT) |-> (bcd_top <= 4'd9))
        else $error("invalid BCD digit after conversion");

    a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_DIGIT && $past(pc_reg) == S_SKIP) |-> (bcd_top != 4'd0 || dig_reg == 4'd0))
        else $error("leading zero left before the first printed digit");

endmodule

// ===== dv/text_console_writer_tb.sv =====
// Self-checking testbench of the text console writer: directed and random console actions.
module text_console_writer_tb;
    import tcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = DEFAULT_COLUMNS;
    localparam int ROWS         = DEFAULT_ROWS;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic               write_valid;
        logic [INDEX_W-1:0] cell_index;
        logic [7:0]         char_code;
        logic [INDEX_W-1:0] cursor_index;
        logic               last;
    } cell_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         action = ACT_CHAR;
    logic [31:0]        value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               write_valid;
    logic [INDEX_W-1:0] cell_index;
    logic [7:0]         char_code;
    logic [INDEX_W-1:0] cursor_index;
    logic               last;

    // Cursor as the predictor sees it.
    logic [4:0] pred_row = '0;
    logic [6:0] pred_col = '0;

    cell_word_t cells_due[$];
    cell_word_t action_words[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int action_count[4] = '{0, 0, 0, 0};

    // Sender and receiver idling controls, set per test.
    int gap_max       = 0;
    int burst_max     = 1;
    int burst_left    = 0;
    int stall_pct     = 0;
    int stall_run_max = 1;
    int stall_run     = 0;
    bit stalling      = 1'b0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_valid  (write_valid),
        .cell_index   (cell_index),
        .char_code    (char_code),
        .cursor_index (cursor_index),
        .last         (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles with %0d words outstanding",
                 CYCLE_LIMIT, cells_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver stalls in runs of random length.
    always @(posedge clk)
    begin
        if (stall_run <= 0)
        begin
            stalling  = ($urandom_range(99) < stall_pct);
            stall_run = $urandom_range(stall_run_max, 1);
        end
        stall_run = stall_run - 1;
        out_stall <= stalling;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("ERROR: %s", msg);
    endtask

    function automatic logic [INDEX_W-1:0] cursor_cell();
        return INDEX_W'(int'(pred_col) + COLUMNS * int'(pred_row));
    endfunction

    function automatic void advance_row();
        pred_col = '0;
        pred_row = (int'(pred_row) == ROWS - 1) ? 5'd0 : pred_row + 5'd1;
    endfunction

    function automatic void predict_put(input logic [7:0] ch);
        logic [INDEX_W-1:0] cell_idx;
        if (ch == CHAR_NEWLINE)
        begin
            advance_row();
            action_words.push_back('{1'b0, '0, 8'h00, cursor_cell(), 1'b0});
        end
        else
        begin
            cell_idx = cursor_cell();
            if (int'(pred_col) == COLUMNS - 1)
                advance_row();
            else
                pred_col = pred_col + 7'd1;
            action_words.push_back('{1'b1, cell_idx, ch, cursor_cell(), 1'b0});
        end
    endfunction

    function automatic void predict_action(input action_t act, input logic [31:0] val);
        logic [31:0] mag;
        logic [31:0] scale;
        logic [31:0] digit;
        logic [3:0]  nibble;
        action_words.delete();
        case (act)
            ACT_CHAR:
                predict_put(val[7:0]);
            ACT_DEC:
            begin
                mag = val;
                if (val[31])
                begin
                    predict_put(CHAR_MINUS);
                    mag = 32'd0 - val;
                end
                scale = 32'd1;
                while (mag / scale >= 32'd10)
                    scale = scale * 32'd10;
                while (scale > 0)
                begin
                    digit = mag / scale;
                    predict_put(CHAR_ZERO + digit[7:0]);
                    mag   = mag - digit * scale;
                    scale = scale / 32'd10;
                end
            end
            ACT_HEX:
                for (int s = 28; s >= 0; s -= 4)
                begin
                    nibble = val[s +: 4];
                    predict_put(nibble < HEX_TEN ? CHAR_ZERO + 8'(nibble)
                                                 : CHAR_LOWER_A + 8'(nibble - HEX_TEN));
                end
            ACT_BKSP:
                if (pred_col != '0)
                begin
                    pred_col = pred_col - 7'd1;
                    action_words.push_back('{1'b1, cursor_cell(), CHAR_SPACE,
                                             cursor_cell(), 1'b0});
                end
        endcase
        if (action_words.size() > 0)
            action_words[$].last = 1'b1;
        foreach (action_words[k])
            cells_due.push_back(action_words[k]);
    endfunction

    // Sends one word, predicts its results on acceptance, then idles between bursts.
    task automatic send_word(input action_t act, input logic [31:0] val);
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_action(act, val);
        items_sent++;
        action_count[act]++;
        if (burst_left > 0)
            burst_left--;
        else if (gap_max > 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge clk);
            burst_left = $urandom_range(burst_max, 1);
        end
    endtask

    // A backspace at column 0 makes no word, so the wait goes on past the empty queue.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_char_value();
        logic [31:0] val;
        val = $urandom();
        if ($urandom_range(9) == 0)
            val[7:0] = CHAR_NEWLINE;
        return val;
    endfunction

    function automatic logic [31:0] random_dec_value();
        case ($urandom_range(7))
            0, 1:    return $urandom_range(99);
            2:       return 32'd0 - $urandom_range(1000, 1);
            3:       return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4:       return $urandom_range(999999999);
            default: return $urandom();
        endcase
    endfunction

    always @(posedge clk)
    begin
        cell_word_t seen;
        cell_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{write_valid, cell_index, char_code, cursor_index, last};
            if (cells_due.size() == 0)
                note_failure($sformatf("unexpected word wv=%0b cell=%0d char=%02h cur=%0d last=%0b",
                                       seen.write_valid, seen.cell_index, seen.char_code,
                                       seen.cursor_index, seen.last));
            else
            begin
                want = cells_due.pop_front();
                words_checked++;
                if (seen !== want)
                    note_failure($sformatf({"word %0d: expected wv=%0b cell=%0d char=%02h ",
                                            "cur=%0d last=%0b, got wv=%0b cell=%0d char=%02h ",
                                            "cur=%0d last=%0b"},
                                           words_checked, want.write_valid, want.cell_index,
                                           want.char_code, want.cursor_index, want.last,
                                           seen.write_valid, seen.cell_index, seen.char_code,
                                           seen.cursor_index, seen.last));
            end
        end
    end

    task automatic test_directed_cases();
        gap_max       = 3;
        burst_max     = 4;
        stall_pct     = 30;
        stall_run_max = 3;
        send_word(ACT_BKSP, 32'h0000_0000);
        send_word(ACT_CHAR, 32'h0000_0041);
        send_word(ACT_CHAR, 32'h0000_0000);
        send_word(ACT_CHAR, 32'h0000_00FF);
        send_word(ACT_CHAR, 32'hFFFF_FF7E);
        send_word(ACT_BKSP, 32'hFFFF_FFFF);
        send_word(ACT_CHAR, 32'h0000_000A);
        send_word(ACT_CHAR, 32'hFFFF_FF0A);
        send_word(ACT_BKSP, 32'h1234_5678);
        send_word(ACT_DEC,  32'h0000_0000);
        send_word(ACT_DEC,  32'h8000_0000);
        send_word(ACT_DEC,  32'h7FFF_FFFF);
        send_word(ACT_DEC,  32'hFFFF_FFFF);
        send_word(ACT_DEC,  32'd9);
        send_word(ACT_DEC,  32'd10);
        send_word(ACT_DEC,  32'd1000000000);
        send_word(ACT_DEC,  32'd999999999);
        send_word(ACT_HEX,  32'h0000_0000);
        send_word(ACT_HEX,  32'hFFFF_FFFF);
        send_word(ACT_HEX,  32'h89AB_CDEF);
        send_word(ACT_HEX,  32'h0123_4567);
        send_word(ACT_BKSP, 32'h0000_0000);
    endtask

    // Numbers run over the line end, mostly in the middle of a number.
    task automatic test_line_end();
        logic [4:0] start_row;
        gap_max   = 0;
        stall_pct = 0;
        start_row = pred_row;
        while (pred_row == start_row)
            send_word(ACT_HEX, $urandom());
        start_row = pred_row;
        while (pred_row == start_row)
            send_word(ACT_DEC, 32'h8000_0000 | $urandom());
        send_word(ACT_BKSP, $urandom());
    endtask

    // The row wraps from the last one to the first, by newline and by printing.
    task automatic test_screen_end();
        gap_max       = 2;
        burst_max     = 8;
        stall_pct     = 20;
        stall_run_max = 2;
        while (int'(pred_row) != ROWS - 1)
            send_word(ACT_CHAR, {16'($urandom_range(16'hFFFF)), 8'h00, CHAR_NEWLINE});
        send_word(ACT_CHAR, {24'hFFFFFF, CHAR_NEWLINE});
        send_word(ACT_BKSP, 32'h0);
        while (int'(pred_row) != ROWS - 1)
            send_word(ACT_CHAR, {16'($urandom_range(16'hFFFF)), 8'h00, CHAR_NEWLINE});
        while (pred_row != '0)
            send_word(ACT_HEX, $urandom());
    endtask

    task automatic random_phase(input int count);
        logic [31:0] val;
        for (int n = 0; n < count; n++)
        begin
            val = $urandom();
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    send_word(ACT_CHAR, random_char_value());
                8, 9, 10, 11:
                    send_word(ACT_DEC, random_dec_value());
                12, 13, 14:
                    send_word(ACT_HEX, val);
                default:
                    send_word(ACT_BKSP, val);
            endcase
            // Hold the sender now and then until the block has emptied.
            if (n % 40 == 39)
                wait_for_idle();
        end
    endtask

    task automatic test_random_traffic();
        // No idling on either side.
        gap_max   = 0;
        stall_pct = 0;
        random_phase(100);
        wait_for_idle();
        gap_max       = 4;
        burst_max     = 6;
        stall_pct     = 35;
        stall_run_max = 4;
        random_phase(100);
        wait_for_idle();
        // Long receiver stalls and long sender gaps.
        gap_max       = 20;
        burst_max     = 3;
        stall_pct     = 60;
        stall_run_max = 20;
        random_phase(100);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        wait_for_idle();
        test_line_end();
        wait_for_idle();
        test_screen_end();
        wait_for_idle();
        test_random_traffic();
        wait_for_idle();
        if (cells_due.size() != 0)
            note_failure($sformatf("%0d expected words never arrived", cells_due.size()));
        $display("Covered %0d actions (char %0d, dec %0d, hex %0d, backspace %0d)",
                 items_sent, action_count[ACT_CHAR], action_count[ACT_DEC],
                 action_count[ACT_HEX], action_count[ACT_BKSP]);
        $display("Checked %0d output words, %0d failures", words_checked, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
